@@ hdl/stg_pkg.sv @@
// Shared types, constants and the control program of the strip tangent generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package stg_pkg;

  // Fixed-point widths of the datapath.
  localparam int POS_W  = 24;   // Q8.16 position
  localparam int TEX_W  = 16;   // Q2.14 texture coordinate
  localparam int DP_W   = 25;   // position difference
  localparam int DT_W   = 17;   // texture difference
  localparam int PROD_W = 42;   // DP_W x DT_W product
  localparam int DET_W  = 35;   // UV determinant, Q.28
  localparam int NUM_W  = 43;   // numerator, Q.30
  localparam int TAN_W  = 32;   // Q16.16 tangent
  localparam int DIV_STEPS = 32;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  localparam logic [TAN_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [TAN_W-1:0] TAN_MAX = 32'h7FFF_FFFF;
  localparam logic [TAN_W-1:0] TAN_MIN = 32'h8000_0000;

  // Program steps.
  typedef enum logic [3:0] {
    ST_WAIT, ST_CHK, ST_DIFF, ST_MULD, ST_DET, ST_DP, ST_MULN, ST_NUM,
    ST_ABS, ST_DIVINIT, ST_DIVSTEP, ST_STORE, ST_TRI, ST_SHIFT, ST_LAST0, ST_LAST1
  } step_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_LATCH, OP_NONE, OP_DIFF, OP_MULD, OP_DET, OP_DP, OP_MULN, OP_NUM,
    OP_ABS, OP_DIVINIT, OP_DIVSTEP, OP_STORE, OP_TRI, OP_SHIFT, OP_LAST0, OP_LAST1
  } op_t;

  // Jump conditions; when the condition holds the step counter loads the target.
  typedef enum logic [2:0] {
    CD_NEXT, CD_ALWAYS, CD_NO_IN, CD_OUT_BUSY, CD_FEW, CD_NOT_LAST, CD_DIV_BUSY,
    CD_MORE_COMP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } div_stat_t;

  // The control store.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      ST_WAIT:    w = '{OP_LATCH,   CD_NO_IN,     ST_WAIT};
      ST_CHK:     w = '{OP_NONE,    CD_FEW,       ST_SHIFT};
      ST_DIFF:    w = '{OP_DIFF,    CD_NEXT,      ST_WAIT};
      ST_MULD:    w = '{OP_MULD,    CD_NEXT,      ST_WAIT};
      ST_DET:     w = '{OP_DET,     CD_NEXT,      ST_WAIT};
      ST_DP:      w = '{OP_DP,      CD_NEXT,      ST_WAIT};
      ST_MULN:    w = '{OP_MULN,    CD_NEXT,      ST_WAIT};
      ST_NUM:     w = '{OP_NUM,     CD_NEXT,      ST_WAIT};
      ST_ABS:     w = '{OP_ABS,     CD_NEXT,      ST_WAIT};
      ST_DIVINIT: w = '{OP_DIVINIT, CD_NEXT,      ST_WAIT};
      ST_DIVSTEP: w = '{OP_DIVSTEP, CD_DIV_BUSY,  ST_DIVSTEP};
      ST_STORE:   w = '{OP_STORE,   CD_MORE_COMP, ST_DP};
      ST_TRI:     w = '{OP_TRI,     CD_OUT_BUSY,  ST_TRI};
      ST_SHIFT:   w = '{OP_SHIFT,   CD_NOT_LAST,  ST_WAIT};
      ST_LAST0:   w = '{OP_LAST0,   CD_OUT_BUSY,  ST_LAST0};
      ST_LAST1:   w = '{OP_LAST1,   CD_OUT_BUSY,  ST_LAST1};
      default:    w = '{OP_NONE,    CD_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/stg_divider.sv @@
// Restoring divider, one quotient bit per cycle while ctrl.step is high, for |num| * 2^14 / |det|.
// Depends on stg_pkg for widths and the control and status structs.
`default_nettype none

module stg_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire stg_pkg::div_ctrl_t        ctrl,
  input  wire logic [stg_pkg::NUM_W-1:0] an,
  input  wire logic [stg_pkg::DET_W-1:0] ad,
  output      logic [stg_pkg::TAN_W-1:0] quot,
  output      stg_pkg::div_stat_t        stat
);

  localparam int DW = stg_pkg::DET_W;
  localparam int NW = stg_pkg::NUM_W;
  localparam int QW = stg_pkg::TAN_W;
  localparam int CW = stg_pkg::CNT_W;
  // The dividend is an * 2^14; its low QW bits are shifted in one per step.
  localparam int LOW_AN = QW - 14;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] sh_r, sh_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial   = {rem_r, sh_r[QW-1]} - {1'b0, ad};
    qbit    = ~trial[DW];
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (ctrl.init) begin
      rem_nxt = DW'(an >> LOW_AN);
      sh_nxt  = {an[LOW_AN-1:0], 14'b0};
      q_nxt   = '0;
      cnt_nxt = CW'(stg_pkg::DIV_STEPS - 1);
      // The quotient would not fit below 2^31: the result saturates.
      ovf_nxt = {(QW - 14 + DW - NW)'(0), an} >= {1'b0, ad, (QW - 15)'(0)};
    end else if (ctrl.step) begin
      rem_nxt = qbit ? trial[DW-1:0] : {rem_r[DW-2:0], sh_r[QW-1]};
      sh_nxt  = {sh_r[QW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], qbit};
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quot = q_r;
  assign stat = '{busy: (cnt_r != '0), ovf: ovf_r};

endmodule

`default_nettype wire

@@ hdl/strip_tangent_generator_unit.sv @@
// Top level of the strip tangent generator: microcoded sequencer and datapath.
// Depends on stg_pkg and instantiates stg_divider.
`default_nettype none

// Usage
// The input channel carries one vertex per beat: a Q8.16 position, a Q2.14
// texture coordinate and a flag that marks the last vertex of a batch. A beat
// moves when in_valid is high and in_stall is low. The result channel carries
// one Q16.16 tangent per beat with a degenerate flag and a last flag, and moves
// when out_valid is high and out_stall is low.
// A vertex is taken only while the sequencer waits at its first step. From the
// third vertex of a batch on, the block computes the triangle tangent with two
// shared multipliers and one bit-serial divider used in turn for x, y and z.
// Such a vertex passes five setup steps, then for each of x, y and z the
// difference, multiply, subtract, magnitude, divider load, divider and store
// steps, then the result and shift steps. The first two vertices pass only
// the wait, check and shift steps. A last vertex adds two result beats
// holding the latest tangent, or (1,1,1) for a short batch.
// The single output register lets the next vertex be taken while a result
// waits; a stalled receiver holds the sequencer only at a step that must
// hand over a new result. Synchronous reset clears the batch and the output.

module strip_tangent_generator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic signed [23:0]         in_pos_x,
  input  wire logic signed [23:0]         in_pos_y,
  input  wire logic signed [23:0]         in_pos_z,
  input  wire logic signed [15:0]         in_tex_u,
  input  wire logic signed [15:0]         in_tex_v,
  input  wire logic                       in_last_vertex,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic signed [31:0]         out_tan_x,
  output      logic signed [31:0]         out_tan_y,
  output      logic signed [31:0]         out_tan_z,
  output      logic                       out_degenerate,
  output      logic                       out_last_result
);

  localparam int PW  = stg_pkg::POS_W;
  localparam int TW  = stg_pkg::TEX_W;
  localparam int DPW = stg_pkg::DP_W;
  localparam int DTW = stg_pkg::DT_W;
  localparam int MW  = stg_pkg::PROD_W;
  localparam int DEW = stg_pkg::DET_W;
  localparam int NMW = stg_pkg::NUM_W;
  localparam int QW  = stg_pkg::TAN_W;

  // Sequencer state.
  stg_pkg::step_t  step_r, step_nxt;
  stg_pkg::uword_t uw;
  logic            jump;
  logic [1:0]      comp_r, comp_nxt;
  logic [1:0]      seen_r, seen_nxt;

  // Vertex storage: the current vertex and the two before it.
  logic signed [PW-1:0] cur_p_r [3], cur_p_nxt [3];
  logic signed [TW-1:0] cur_uv_r [2], cur_uv_nxt [2];
  logic                 last_r, last_nxt;
  logic signed [PW-1:0] p0_r [3], p0_nxt [3];
  logic signed [PW-1:0] p1_r [3], p1_nxt [3];
  logic signed [TW-1:0] uv0_r [2], uv0_nxt [2];
  logic signed [TW-1:0] uv1_r [2], uv1_nxt [2];

  // Arithmetic registers.
  logic signed [DTW-1:0] du1_r, du1_nxt, dv1_r, dv1_nxt;
  logic signed [DTW-1:0] du2_r, du2_nxt, dv2_r, dv2_nxt;
  logic signed [DPW-1:0] dp1_r, dp1_nxt, dp2_r, dp2_nxt;
  logic signed [MW-1:0]  prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;
  logic signed [DEW-1:0] det_r, det_nxt;
  logic signed [NMW-1:0] num_r, num_nxt;
  logic [NMW-1:0]        an_r, an_nxt;
  logic [DEW-1:0]        ad_r, ad_nxt;
  logic                  neg_r, neg_nxt;

  // Multiplier operands, shared by the determinant and numerator steps.
  logic signed [DPW-1:0] ma0, ma1;
  logic signed [DTW-1:0] mb1;
  logic signed [MW-1:0]  mp0, mp1;

  // Held tangent and the output register.
  logic [QW-1:0] held_r [3], held_nxt [3];
  logic          held_deg_r, held_deg_nxt;
  logic [QW-1:0] res;
  logic          out_free;
  logic          out_valid_r, out_valid_nxt;
  logic [QW-1:0] out_tan_r [3], out_tan_nxt [3];
  logic          out_deg_r, out_deg_nxt, out_last_r, out_last_nxt;

  // Divider.
  stg_pkg::div_ctrl_t dctrl;
  stg_pkg::div_stat_t dstat;
  logic [QW-1:0]      quot;

  stg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dctrl),
    .an    (an_r),
    .ad    (ad_r),
    .quot  (quot),
    .stat  (dstat)
  );

  assign uw       = stg_pkg::ucode(step_r);
  assign in_stall = (step_r != stg_pkg::ST_WAIT);
  assign out_free = !out_valid_r || !out_stall;

  // Jump decision of the current control word.
  always_comb begin
    case (uw.cond)
      stg_pkg::CD_NEXT:      jump = 1'b0;
      stg_pkg::CD_ALWAYS:    jump = 1'b1;
      stg_pkg::CD_NO_IN:     jump = !in_valid;
      stg_pkg::CD_OUT_BUSY:  jump = !out_free;
      stg_pkg::CD_FEW:       jump = (seen_r < 2'd2);
      stg_pkg::CD_NOT_LAST:  jump = !last_r;
      stg_pkg::CD_DIV_BUSY:  jump = dstat.busy;
      stg_pkg::CD_MORE_COMP: jump = (comp_r != 2'd2);
      default:               jump = 1'b0;
    endcase
    step_nxt = jump ? uw.target : stg_pkg::step_t'(step_r + 4'd1);
  end

  // Multiplier operand selection: determinant terms or numerator terms.
  always_comb begin
    if (uw.op == stg_pkg::OP_MULD) begin
      ma0 = DPW'(du1_r);
      ma1 = DPW'(dv1_r);
      mb1 = du2_r;
    end else begin
      ma0 = dp1_r;
      ma1 = dp2_r;
      mb1 = dv1_r;
    end
  end

  assign mp0 = ma0 * dv2_r;
  assign mp1 = ma1 * mb1;

  // Saturated, signed quotient of the current component, or zero for a zero determinant.
  always_comb begin
    if (det_r == '0) begin
      res = '0;
    end else if (dstat.ovf) begin
      res = neg_r ? stg_pkg::TAN_MIN : stg_pkg::TAN_MAX;
    end else begin
      res = neg_r ? (~quot + 1'b1) : quot;
    end
  end

  // Datapath actions of each operation.
  always_comb begin
    comp_nxt      = comp_r;
    seen_nxt      = seen_r;
    cur_p_nxt     = cur_p_r;
    cur_uv_nxt    = cur_uv_r;
    last_nxt      = last_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    uv0_nxt       = uv0_r;
    uv1_nxt       = uv1_r;
    du1_nxt       = du1_r;
    dv1_nxt       = dv1_r;
    du2_nxt       = du2_r;
    dv2_nxt       = dv2_r;
    dp1_nxt       = dp1_r;
    dp2_nxt       = dp2_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    det_nxt       = det_r;
    num_nxt       = num_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    neg_nxt       = neg_r;
    held_nxt      = held_r;
    held_deg_nxt  = held_deg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_tan_nxt   = out_tan_r;
    out_deg_nxt   = out_deg_r;
    out_last_nxt  = out_last_r;
    dctrl         = '0;

    case (uw.op)
      stg_pkg::OP_LATCH: begin
        if (in_valid) begin
          cur_p_nxt[0]  = in_pos_x;
          cur_p_nxt[1]  = in_pos_y;
          cur_p_nxt[2]  = in_pos_z;
          cur_uv_nxt[0] = in_tex_u;
          cur_uv_nxt[1] = in_tex_v;
          last_nxt      = in_last_vertex;
        end
      end
      stg_pkg::OP_DIFF: begin
        du1_nxt  = DTW'(uv1_r[0]) - DTW'(uv0_r[0]);
        dv1_nxt  = DTW'(uv1_r[1]) - DTW'(uv0_r[1]);
        du2_nxt  = DTW'(cur_uv_r[0]) - DTW'(uv0_r[0]);
        dv2_nxt  = DTW'(cur_uv_r[1]) - DTW'(uv0_r[1]);
        comp_nxt = 2'd0;
      end
      stg_pkg::OP_MULD, stg_pkg::OP_MULN: begin
        prod_a_nxt = mp0;
        prod_b_nxt = mp1;
      end
      stg_pkg::OP_DET: begin
        det_nxt = DEW'(prod_a_r - prod_b_r);
      end
      stg_pkg::OP_DP: begin
        dp1_nxt = DPW'(p1_r[comp_r]) - DPW'(p0_r[comp_r]);
        dp2_nxt = DPW'(cur_p_r[comp_r]) - DPW'(p0_r[comp_r]);
      end
      stg_pkg::OP_NUM: begin
        num_nxt = NMW'(prod_a_r) - NMW'(prod_b_r);
      end
      stg_pkg::OP_ABS: begin
        an_nxt  = num_r[NMW-1] ? NMW'(-num_r) : NMW'(num_r);
        ad_nxt  = det_r[DEW-1] ? DEW'(-det_r) : DEW'(det_r);
        neg_nxt = num_r[NMW-1] ^ det_r[DEW-1];
      end
      stg_pkg::OP_DIVINIT: begin
        dctrl.init = 1'b1;
      end
      stg_pkg::OP_DIVSTEP: begin
        dctrl.step = 1'b1;
      end
      stg_pkg::OP_STORE: begin
        held_nxt[comp_r] = res;
        held_deg_nxt     = (det_r == '0);
        comp_nxt         = comp_r + 2'd1;
      end
      stg_pkg::OP_TRI, stg_pkg::OP_LAST0, stg_pkg::OP_LAST1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tan_nxt   = held_r;
          out_deg_nxt   = held_deg_r;
          out_last_nxt  = (uw.op == stg_pkg::OP_LAST1);
          if (uw.op == stg_pkg::OP_LAST1) begin
            // The batch is over: back to the reset values.
            seen_nxt     = 2'd0;
            held_deg_nxt = 1'b0;
            for (int i = 0; i < 3; i++) begin
              held_nxt[i] = stg_pkg::ONE_Q16;
            end
          end
        end
      end
      stg_pkg::OP_SHIFT: begin
        p0_nxt  = p1_r;
        p1_nxt  = cur_p_r;
        uv0_nxt = uv1_r;
        uv1_nxt = cur_uv_r;
        if (seen_r < 2'd2) begin
          seen_nxt = seen_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= stg_pkg::ST_WAIT;
      comp_r      <= 2'd0;
      seen_r      <= 2'd0;
      out_valid_r <= 1'b0;
      held_deg_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= stg_pkg::ONE_Q16;
      end
    end else begin
      step_r      <= step_nxt;
      comp_r      <= comp_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      held_deg_r  <= held_deg_nxt;
      held_r      <= held_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_p_r    <= cur_p_nxt;
    cur_uv_r   <= cur_uv_nxt;
    last_r     <= last_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    uv0_r      <= uv0_nxt;
    uv1_r      <= uv1_nxt;
    du1_r      <= du1_nxt;
    dv1_r      <= dv1_nxt;
    du2_r      <= du2_nxt;
    dv2_r      <= dv2_nxt;
    dp1_r      <= dp1_nxt;
    dp2_r      <= dp2_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_b_r   <= prod_b_nxt;
    det_r      <= det_nxt;
    num_r      <= num_nxt;
    an_r       <= an_nxt;
    ad_r       <= ad_nxt;
    neg_r      <= neg_nxt;
    out_tan_r  <= out_tan_nxt;
    out_deg_r  <= out_deg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tan_x       = out_tan_r[0];
  assign out_tan_y       = out_tan_r[1];
  assign out_tan_z       = out_tan_r[2];
  assign out_degenerate  = out_deg_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for strip_tangent_generator_unit: directed vertex batches, then
// random strips, each checked against a tangent predictor kept inside this file.
// Depends on stg_pkg and the RTL of strip_tangent_generator_unit only.

module tb;

  // One row of vertex stimulus. When has_known is set, every result beat caused by
  // this vertex must carry the typed-in tangent and degenerate flag. The number of
  // beats and their last flags still come from the predictor.
  typedef struct packed {
    logic [stg_pkg::POS_W-1:0] pos_x;
    logic [stg_pkg::POS_W-1:0] pos_y;
    logic [stg_pkg::POS_W-1:0] pos_z;
    logic [stg_pkg::TEX_W-1:0] tex_u;
    logic [stg_pkg::TEX_W-1:0] tex_v;
    logic                      last_vertex;
    logic                      has_known;
    logic [stg_pkg::TAN_W-1:0] known_x;
    logic [stg_pkg::TAN_W-1:0] known_y;
    logic [stg_pkg::TAN_W-1:0] known_z;
    logic                      known_deg;
  } vertex_row_t;

  // One tangent beat on the result channel.
  typedef struct packed {
    logic [stg_pkg::TAN_W-1:0] tan_x;
    logic [stg_pkg::TAN_W-1:0] tan_y;
    logic [stg_pkg::TAN_W-1:0] tan_z;
    logic                      degenerate;
    logic                      last_result;
  } tangent_beat_t;

  // Receiver behaviors. Each one runs for a random span before the next is drawn.
  typedef enum logic [1:0] {RX_FREE, RX_SPARSE, RX_DENSE, RX_PERIODIC} rx_style_t;

  localparam logic [stg_pkg::POS_W-1:0] POS_MIN = 24'h80_0000;
  localparam logic [stg_pkg::POS_W-1:0] POS_MAX = 24'h7F_FFFF;
  localparam logic [stg_pkg::TEX_W-1:0] TEX_MIN = 16'h8000;
  localparam logic [stg_pkg::TEX_W-1:0] TEX_MAX = 16'h7FFF;
  localparam logic [stg_pkg::TEX_W-1:0] TEX_ONE = 16'h4000;   // 1.0 in Q2.14
  // The position span from the lowest to the highest value, in Q16.16.
  localparam logic [stg_pkg::TAN_W-1:0] FULL_SPAN = 32'h00FF_FFFF;
  localparam logic [stg_pkg::TAN_W-1:0] ONE_TAN = stg_pkg::ONE_Q16;
  localparam logic [stg_pkg::TAN_W-1:0] MAX_TAN = stg_pkg::TAN_MAX;
  localparam logic [stg_pkg::TAN_W-1:0] MIN_TAN = stg_pkg::TAN_MIN;

  localparam int RANDOM_VERTICES = 180;
  localparam int HOLDOFF_CYCLES  = 2500;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES    = 300;    // drain margin, longer than a triangle vertex takes
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel. The payload comes straight from the row being offered.
  logic        in_valid = 1'b0;
  logic        in_stall;
  vertex_row_t offered_row = '0;

  // Result channel.
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [stg_pkg::TAN_W-1:0] out_tan_x;
  logic [stg_pkg::TAN_W-1:0] out_tan_y;
  logic [stg_pkg::TAN_W-1:0] out_tan_z;
  logic                      out_degenerate;
  logic                      out_last_result;

  // Predictor state: the last two vertices of the strip, the number of vertices seen
  // in the batch (saturating at two) and the tangent that a last vertex repeats.
  longint                    strip_pos [0:1][0:2];
  longint                    strip_tex [0:1][0:1];
  int                        strip_depth = 0;
  logic [stg_pkg::TAN_W-1:0] held_tan [0:2];
  logic                      held_deg = 1'b0;

  tangent_beat_t pending_tangents [$];
  vertex_row_t   directed_rows [$];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic holdoff_armed = 1'b0;

  always #5 clk = ~clk;

  strip_tangent_generator_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (offered_row.pos_x),
    .in_pos_y       (offered_row.pos_y),
    .in_pos_z       (offered_row.pos_z),
    .in_tex_u       (offered_row.tex_u),
    .in_tex_v       (offered_row.tex_v),
    .in_last_vertex (offered_row.last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tan_x      (out_tan_x),
    .out_tan_y      (out_tan_y),
    .out_tan_z      (out_tan_z),
    .out_degenerate (out_degenerate),
    .out_last_result(out_last_result)
  );

  // Counts a failure and prints the first few of them in full.
  task automatic note_mismatch(input string what, input tangent_beat_t want,
                               input tangent_beat_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %0s: want x=%0d y=%0d z=%0d deg=%0b last=%0b", $time, what,
               $signed(want.tan_x), $signed(want.tan_y), $signed(want.tan_z),
               want.degenerate, want.last_result);
      $display("[%0t] %0s:  got x=%0d y=%0d z=%0d deg=%0b last=%0b", $time, what,
               $signed(got.tan_x), $signed(got.tan_y), $signed(got.tan_z),
               got.degenerate, got.last_result);
    end
  endtask

  task automatic add_row(input logic [23:0] px, input logic [23:0] py,
                         input logic [23:0] pz, input logic [15:0] u,
                         input logic [15:0] v, input logic last, input logic known,
                         input logic [31:0] kx, input logic [31:0] ky,
                         input logic [31:0] kz, input logic kdeg);
    vertex_row_t row;
    row = {px, py, pz, u, v, last, known, kx, ky, kz, kdeg};
    directed_rows = {directed_rows, row};
  endtask

  // Queues one expected beat from the held tangent, or from the row's typed-in value.
  task automatic push_tangent(input vertex_row_t row, input logic last);
    tangent_beat_t beat;
    if (row.has_known)
      beat = {row.known_x, row.known_y, row.known_z, row.known_deg, last};
    else
      beat = {held_tan[0], held_tan[1], held_tan[2], held_deg, last};
    pending_tangents = {pending_tangents, beat};
  endtask

  // Advances the strip by one accepted vertex and queues the beats it must cause.
  task automatic predict_vertex(input vertex_row_t row);
    longint      p [0:2];
    longint      uv [0:1];
    longint      du1, dv1, du2, dv2, det, dp1, dp2, num;
    logic [63:0] mag_num, mag_det, quot;
    int          j;
    p[0]  = $signed(row.pos_x);
    p[1]  = $signed(row.pos_y);
    p[2]  = $signed(row.pos_z);
    uv[0] = $signed(row.tex_u);
    uv[1] = $signed(row.tex_v);

    // From the third vertex on, the sliding triangle (oldest, middle, newest) gives
    // a tangent. Position deltas are Q.16, UV deltas Q.14, so the quotient needs a
    // further 14-bit shift to land on Q16.16.
    if (strip_depth >= 2) begin
      du1 = strip_tex[1][0] - strip_tex[0][0];
      dv1 = strip_tex[1][1] - strip_tex[0][1];
      du2 = uv[0] - strip_tex[0][0];
      dv2 = uv[1] - strip_tex[0][1];
      det = du1 * dv2 - dv1 * du2;
      for (j = 0; j < 3; j++) begin
        dp1 = strip_pos[1][j] - strip_pos[0][j];
        dp2 = p[j] - strip_pos[0][j];
        num = dp1 * dv2 - dp2 * dv1;
        mag_num = (num < 0) ? -num : num;
        mag_det = (det < 0) ? -det : det;
        if (det == 0) begin
          held_tan[j] = '0;
        end else begin
          // Truncate the magnitude toward zero, then apply the sign and saturate.
          quot = (mag_num << 14) / mag_det;
          if ((num < 0) != (det < 0))
            held_tan[j] = (quot >= 64'h8000_0000) ? MIN_TAN : -quot[31:0];
          else
            held_tan[j] = (quot > 64'h7FFF_FFFF) ? MAX_TAN : quot[31:0];
        end
      end
      held_deg = (det == 0);
      push_tangent(row, 1'b0);
    end

    for (j = 0; j < 3; j++) begin
      strip_pos[0][j] = strip_pos[1][j];
      strip_pos[1][j] = p[j];
    end
    for (j = 0; j < 2; j++) begin
      strip_tex[0][j] = strip_tex[1][j];
      strip_tex[1][j] = uv[j];
    end
    if (strip_depth < 2)
      strip_depth++;

    // A last vertex repeats the held tangent twice, then the batch starts over.
    if (row.last_vertex) begin
      push_tangent(row, 1'b0);
      push_tangent(row, 1'b1);
      strip_depth = 0;
      for (j = 0; j < 3; j++)
        held_tan[j] = ONE_TAN;
      held_deg = 1'b0;
    end
  endtask

  // Offers one vertex beat. The sender works in bursts with random gaps in between;
  // about a quarter of the bursts follow the previous one with no gap at all. The
  // task is entered and left at a falling edge, and the payload stays put while the
  // block stalls.
  task automatic offer_vertex(input vertex_row_t row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    offered_row <= row;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predict_vertex(row);
    @(negedge clk);
  endtask

  // Random Q8.16 position: extremes, full range, or values near zero.
  function automatic logic [23:0] pick_pos();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0:       w = {8'h00, POS_MIN};
      1:       w = {8'h00, POS_MAX};
      2, 3, 4: w = $urandom();
      default: w = $urandom_range(0, 8191) - 4096;
    endcase
    return w[23:0];
  endfunction

  // Random Q2.14 texture coordinate: extremes, 1.0, full range, or near zero.
  function automatic logic [15:0] pick_tex();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = {16'h0000, TEX_MIN};
      1:       w = {16'h0000, TEX_MAX};
      2:       w = {16'h0000, TEX_ONE};
      3, 4, 5: w = $urandom();
      default: w = $urandom_range(0, 1023) - 512;
    endcase
    return w[15:0];
  endfunction

  // Stimulus and end of run.
  initial begin
    vertex_row_t   row;
    tangent_beat_t leftover;
    int            sent;
    int            strip_len;
    int            k;
    logic [15:0]   prev_u, prev_v;

    for (k = 0; k < 3; k++)
      held_tan[k] = ONE_TAN;

    // A single-vertex batch and a two-vertex batch: no triangle, each only two (1,1,1).
    add_row(24'h00_0000, 24'h00_0000, 24'h00_0000, 16'h0000, 16'h0000, 1'b1,
            1'b1, ONE_TAN, ONE_TAN, ONE_TAN, 1'b0);
    add_row(POS_MAX, POS_MIN, 24'h01_0000, TEX_MAX, TEX_MIN, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(POS_MIN, POS_MAX, 24'h00_0000, 16'h0000, 16'h0000, 1'b1,
            1'b1, ONE_TAN, ONE_TAN, ONE_TAN, 1'b0);
    // All three UVs equal: zero determinant, so a zero tangent flagged degenerate,
    // and the last-vertex copies repeat it.
    add_row(24'h12_3456, 24'hFE_DCBA, 24'h00_0000, TEX_ONE, TEX_ONE, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h01_0000, 24'h02_0000, 24'h03_0000, TEX_ONE, TEX_ONE, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(POS_MAX, POS_MIN, POS_MAX, TEX_ONE, TEX_ONE, 1'b1, 1'b1, 0, 0, 0, 1'b1);
    // Unit UV frame: the tangent is exactly the first edge, here the full span.
    add_row(POS_MIN, POS_MIN, POS_MIN, 16'h0000, 16'h0000, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(POS_MAX, POS_MAX, POS_MAX, TEX_ONE, 16'h0000, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h00_0000, 24'h00_0000, 24'h00_0000, 16'h0000, TEX_ONE, 1'b1,
            1'b1, FULL_SPAN, FULL_SPAN, FULL_SPAN, 1'b0);
    // Tiny UV frame: the full span saturates high in x and low in y, z stays zero.
    // The strip then slides on with extreme and one-lsb coordinates.
    add_row(POS_MIN, POS_MAX, 24'h05_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(POS_MAX, POS_MIN, 24'h05_0000, 16'h0001, 16'h0000, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h12_3456, 24'hF5_4322, 24'h00_0000, 16'h0000, 16'h0001, 1'b0,
            1'b1, MAX_TAN, MIN_TAN, 32'h0000_0000, 1'b0);
    add_row(24'h3A_0000, 24'hC6_0000, POS_MAX, TEX_MIN, TEX_MAX, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h00_0001, 24'hFF_FFFF, POS_MIN, 16'h0001, 16'hFFFF, 1'b1, 1'b0, 0, 0, 0, 1'b0);
    // Texture coordinates at their extremes.
    add_row(POS_MAX, POS_MIN, 24'h00_0000, TEX_MIN, TEX_MIN, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(POS_MIN, POS_MAX, 24'hFF_FFFF, TEX_MAX, TEX_MIN, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h40_0000, 24'hC0_0000, 24'h00_0100, TEX_MIN, TEX_MAX, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h0F_0F0F, 24'hF0_F0F0, 24'h55_5555, TEX_MAX, TEX_MAX, 1'b1, 1'b0, 0, 0, 0, 1'b0);
    // An ordinary strip with a negative determinant.
    add_row(24'h02_0000, 24'h01_0000, 24'hFF_0000, 16'h2000, 16'h1000, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'h01_8000, 24'hFE_8000, 24'h00_4000, 16'h1000, 16'h3000, 1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_row(24'hFC_0000, 24'h0A_AAAA, 24'h15_5555, 16'h3000, 16'h0800, 1'b1, 1'b0, 0, 0, 0, 1'b0);

    // Synchronous reset, applied once.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_vertex(directed_rows[i]);

    // Random strips. Most batches are well formed with random content and a last
    // vertex at the end; short batches of one or two vertices act as broken strips.
    // Now and then a UV repeats so that the determinant is zero. The receiver is
    // told to hold off once, early on, while vertices keep coming.
    holdoff_armed = 1'b1;
    sent = 0;
    while (sent < RANDOM_VERTICES) begin
      strip_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 14);
      prev_u = '0;
      prev_v = '0;
      for (k = 0; k < strip_len; k++) begin
        row = '0;
        row.pos_x = pick_pos();
        row.pos_y = pick_pos();
        row.pos_z = pick_pos();
        if (k > 0 && $urandom_range(0, 7) == 0) begin
          row.tex_u = prev_u;
          row.tex_v = prev_v;
        end else begin
          row.tex_u = pick_tex();
          row.tex_v = pick_tex();
        end
        row.last_vertex = (k == strip_len - 1);
        prev_u = row.tex_u;
        prev_v = row.tex_v;
        offer_vertex(row);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected beat, then a margin for anything stray.
    while (pending_tangents.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_tangents.size() != 0) begin
      leftover = pending_tangents.pop_front();
      note_mismatch("missing beat", leftover, '0);
    end

    if (mismatch_count == 0)
      $display("strip_tangent_generator_unit regression: pass");
    else
      $display("strip_tangent_generator_unit regression: fail");
    $finish;
  end

  // Receiver. It changes style every so often: no stalls, light or heavy random
  // stalls, or a fixed duty pattern. Once armed, it holds off for a long stretch
  // so that the output register stays full and the block stalls its input.
  initial begin
    rx_style_t style;
    int        span;
    int        period;
    int        phase;
    logic      holdoff_done;
    holdoff_done = 1'b0;
    style  = RX_FREE;
    span   = 0;
    period = 4;
    phase  = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_armed && !holdoff_done) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      if (span == 0) begin
        style  = rx_style_t'($urandom_range(0, 3));
        span   = $urandom_range(20, 300);
        period = $urandom_range(2, 7);
        phase  = 0;
      end
      span--;
      phase++;
      case (style)
        RX_FREE:     out_stall <= 1'b0;
        RX_SPARSE:   out_stall <= ($urandom_range(0, 9) < 3);
        RX_DENSE:    out_stall <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: out_stall <= ((phase % period) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Result checker: each accepted beat is compared with the oldest expectation.
  always @(posedge clk) begin
    tangent_beat_t got;
    tangent_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_tan_x, out_tan_y, out_tan_z, out_degenerate, out_last_result};
      if (pending_tangents.size() == 0) begin
        note_mismatch("unexpected beat", '0, got);
      end else begin
        want = pending_tangents.pop_front();
        if (got !== want)
          note_mismatch("tangent mismatch", want, got);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("strip_tangent_generator_unit regression: fail");
      $finish;
    end
  end

endmodule

@@ files.f @@
hdl/stg_pkg.sv
hdl/stg_divider.sv
hdl/strip_tangent_generator_unit.sv
dv/tb.sv
